@@ src/tascs_pkg.sv @@
// ----------------------------------------------------------------------------
// tascs_pkg: shared definitions for the two-axis sweep capture sequencer
// Result command codes, register indexes, sweep phases, control states and
// reset values of the configuration registers.
// ----------------------------------------------------------------------------
package tascs_pkg;

   localparam int SAMPLE_WIDTH_DEF = 16;

   localparam logic [10:0] MAX_CAPTURE = 11'd1024;

   // Magnitude of (end - start) * index is below 2^40.
   localparam int DIV_STEPS = 40;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [7:0]  INNER_DIV_RESET = 8'd72;
   localparam logic [7:0]  OUTER_DIV_RESET = 8'd18;
   localparam logic [15:0] SETTLE_RESET    = 16'd200;
   localparam logic [19:0] HOME_SEEK_RESET = 20'd10000;

   typedef enum logic [3:0] {
      CMD_NONE          = 4'd0,
      CMD_MOVE_OUTER    = 4'd1,
      CMD_MOVE_INNER    = 4'd2,
      CMD_HOME_INNER    = 4'd3,
      CMD_CAPTURE_START = 4'd4,
      CMD_FILTER        = 4'd5,
      CMD_HEADER        = 4'd6,
      CMD_SAMPLE        = 4'd7,
      CMD_END           = 4'd8,
      CMD_STOP_ALL      = 4'd9
   } command_type;

   typedef enum logic [2:0] {
      CSR_AXIS1_MIN       = 3'd0,
      CSR_AXIS1_MAX       = 3'd1,
      CSR_AXIS2_MIN       = 3'd2,
      CSR_AXIS2_MAX       = 3'd3,
      CSR_INNER_DIVISIONS = 3'd4,
      CSR_OUTER_DIVISIONS = 3'd5,
      CSR_SETTLE_MS       = 3'd6,
      CSR_HOME_SEEK_STEPS = 3'd7
   } csr_index_type;

   typedef enum logic [10:0] {
      PH_INIT       = 11'b000_0000_0001,
      PH_OUTER_WAIT = 11'b000_0000_0010,
      PH_HOME_SEEK  = 11'b000_0000_0100,
      PH_INNER_WAIT = 11'b000_0000_1000,
      PH_SETTLE     = 11'b000_0001_0000,
      PH_CAP_START  = 11'b000_0010_0000,
      PH_CAP_WAIT   = 11'b000_0100_0000,
      PH_FILTER     = 11'b000_1000_0000,
      PH_SEND       = 11'b001_0000_0000,
      PH_NEXT       = 11'b010_0000_0000,
      PH_DONE       = 11'b100_0000_0000
   } phase_type;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b00_0001,
      ST_DIFF = 6'b00_0010,
      ST_MUL  = 6'b00_0100,
      ST_DIV  = 6'b00_1000,
      ST_ADD  = 6'b01_0000,
      ST_OUT  = 6'b10_0000
   } state_type;

endpackage

@@ src/two_axis_sweep_capture_sequencer.sv @@
// ----------------------------------------------------------------------------
// two_axis_sweep_capture_sequencer: raster sweep and capture sequencer
// Walks an inner by outer grid, homes the inner axis at each row, waits for
// settling, runs a capture and streams a step header plus its samples.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* is a valid/ready channel of poll or restart items carrying the
//    motor, limit, capture and clock status. rsp_* is a valid/ready channel
//    of result items; rsp_last marks the final result of one input item.
//  - csr_* writes the bounds, divisions, settle time and home overshoot.
//    Write only while the block is idle.
//  - One item at a time: req_ready is high only while no result is pending.
//    An item with no result leaves the block idle and ready. A result without
//    a grid target passes the add step before it is shown; a grid move target
//    passes the difference, multiply, 40 iterations of the shared restoring
//    divider (one quotient bit per cycle) and add steps.
//    A header with a sample gives two results on consecutive transfers.
//  - A stalled receiver simply holds rsp_valid and the result; no new item
//    is taken until the last result of the current item is transferred.
//  - Synchronous reset returns the sweep to its init phase, zeroes the grid
//    indices and loads the register defaults.
// ----------------------------------------------------------------------------
module two_axis_sweep_capture_sequencer #(
   parameter int SAMPLE_WIDTH = tascs_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // configuration writes
   input  logic                           csr_write_enable,
   input  logic [2:0]                     csr_index,
   input  logic [31:0]                    csr_write_data,
   // poll / restart items
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_operation,
   input  logic                           req_inner_moving,
   input  logic                           req_outer_moving,
   input  logic                           req_inner_limit_hit,
   input  logic                           req_capture_complete,
   input  logic [31:0]                    req_now_ms,
   input  logic [10:0]                    req_capture_length,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_i,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_q,
   input  logic signed [31:0]             req_inner_position,
   input  logic signed [31:0]             req_outer_position,
   // results
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [3:0]                     rsp_command,
   output logic signed [31:0]             rsp_target,
   output logic [7:0]                     rsp_inner_index,
   output logic [7:0]                     rsp_outer_index,
   output logic signed [31:0]             rsp_report_inner_position,
   output logic signed [31:0]             rsp_report_outer_position,
   output logic [10:0]                    rsp_report_count,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_out_sample_i,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_out_sample_q,
   output logic                           rsp_last
);

   localparam int DW = tascs_pkg::DIV_STEPS;
   localparam int CW = tascs_pkg::DIV_CNT_W;

   // configuration registers
   logic [31:0] axis1_min_ff, axis1_max_ff, axis2_min_ff, axis2_max_ff;
   logic [7:0]  inner_div_ff, outer_div_ff;
   logic [15:0] settle_ms_ff;
   logic [19:0] home_seek_ff;

   // sweep state
   tascs_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  inner_step_ff, inner_step_in;
   logic [7:0]  outer_step_ff, outer_step_in;
   logic [31:0] settle_origin_ff, settle_origin_in;
   logic [10:0] send_position_ff, send_position_in;
   logic [31:0] in_start_ff, in_start_in, in_end_ff, in_end_in;
   logic [31:0] out_start_ff, out_start_in, out_end_ff, out_end_in;

   // control and target arithmetic
   tascs_pkg::state_type state_ff;
   logic [31:0] op_base_ff, op_base_in;
   logic [31:0] op_end_ff, op_end_in;
   logic [7:0]  op_idx_ff, op_idx_in;
   logic [7:0]  op_total_ff, op_total_in;
   logic [31:0] op_addend_ff, op_addend_in;
   logic        op_div_ff, op_div_in;
   logic [32:0] diff_ff;
   logic        neg_ff;
   logic [DW-1:0] quo_ff;
   logic [7:0]  rem_ff;
   logic [CW-1:0] cnt_ff;

   // second result (a sample after a header)
   logic                    r1_pending_ff;
   logic [SAMPLE_WIDTH-1:0] r1_sample_i_ff, r1_sample_q_ff;

   // result register
   tascs_pkg::command_type rsp_command_ff;
   logic [31:0]             rsp_target_ff;
   logic [7:0]              rsp_inner_index_ff, rsp_outer_index_ff;
   logic [31:0]             rsp_rin_ff, rsp_rout_ff;
   logic [10:0]             rsp_count_ff;
   logic [SAMPLE_WIDTH-1:0] rsp_sample_i_ff, rsp_sample_q_ff;
   logic                    rsp_last_ff;

   // decision for the item on the request port
   logic                    dec_r0_en, dec_r1_en;
   tascs_pkg::command_type  dec_cmd;
   logic [31:0]             dec_rin, dec_rout;
   logic [10:0]             dec_cnt;
   logic [SAMPLE_WIDTH-1:0] dec_si, dec_sq;

   logic        req_xfer, rsp_xfer;
   logic [10:0] cap_len;
   logic [31:0] elapsed;
   logic        settle_done;

   // datapath of the shared unit
   logic [32:0] diff_in;
   logic [32:0] mag;
   logic [DW-1:0] prod;
   logic [8:0]  trial;
   logic        trial_ge;
   logic [8:0]  trial_sub;
   logic [31:0] add_operand;
   logic [31:0] add_sum;

   assign req_ready = (state_ff == tascs_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == tascs_pkg::ST_OUT);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_xfer  = rsp_valid && rsp_ready;

   assign rsp_command               = rsp_command_ff;
   assign rsp_target                = rsp_target_ff;
   assign rsp_inner_index           = rsp_inner_index_ff;
   assign rsp_outer_index           = rsp_outer_index_ff;
   assign rsp_report_inner_position = rsp_rin_ff;
   assign rsp_report_outer_position = rsp_rout_ff;
   assign rsp_report_count          = rsp_count_ff;
   assign rsp_out_sample_i          = rsp_sample_i_ff;
   assign rsp_out_sample_q          = rsp_sample_q_ff;
   assign rsp_last                  = rsp_last_ff;

   assign cap_len = (req_capture_length > tascs_pkg::MAX_CAPTURE) ?
                    tascs_pkg::MAX_CAPTURE : req_capture_length;
   // wrapping millisecond compare
   assign elapsed     = req_now_ms - settle_origin_ff;
   assign settle_done = (elapsed >= {16'd0, settle_ms_ff});

   // ---------------------------------------------------------------------
   // Configuration port
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         axis1_min_ff <= '0;
         axis1_max_ff <= '0;
         axis2_min_ff <= '0;
         axis2_max_ff <= '0;
         inner_div_ff <= tascs_pkg::INNER_DIV_RESET;
         outer_div_ff <= tascs_pkg::OUTER_DIV_RESET;
         settle_ms_ff <= tascs_pkg::SETTLE_RESET;
         home_seek_ff <= tascs_pkg::HOME_SEEK_RESET;
      end else if (csr_write_enable) begin
         unique case (tascs_pkg::csr_index_type'(csr_index))
            tascs_pkg::CSR_AXIS1_MIN:       axis1_min_ff <= csr_write_data;
            tascs_pkg::CSR_AXIS1_MAX:       axis1_max_ff <= csr_write_data;
            tascs_pkg::CSR_AXIS2_MIN:       axis2_min_ff <= csr_write_data;
            tascs_pkg::CSR_AXIS2_MAX:       axis2_max_ff <= csr_write_data;
            tascs_pkg::CSR_INNER_DIVISIONS: inner_div_ff <= csr_write_data[7:0];
            tascs_pkg::CSR_OUTER_DIVISIONS: outer_div_ff <= csr_write_data[7:0];
            tascs_pkg::CSR_SETTLE_MS:       settle_ms_ff <= csr_write_data[15:0];
            tascs_pkg::CSR_HOME_SEEK_STEPS: home_seek_ff <= csr_write_data[19:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Sweep decision for the item at the request port. A target is always
   // base + addend, or base + (end - base) * idx / total when op_div is set.
   // ---------------------------------------------------------------------
   always_comb begin
      phase_in         = phase_ff;
      inner_step_in    = inner_step_ff;
      outer_step_in    = outer_step_ff;
      settle_origin_in = settle_origin_ff;
      send_position_in = send_position_ff;
      in_start_in      = in_start_ff;
      in_end_in        = in_end_ff;
      out_start_in     = out_start_ff;
      out_end_in       = out_end_ff;
      dec_r0_en        = 1'b0;
      dec_r1_en        = 1'b0;
      dec_cmd          = tascs_pkg::CMD_NONE;
      dec_rin          = '0;
      dec_rout         = '0;
      dec_cnt          = '0;
      dec_si           = '0;
      dec_sq           = '0;
      op_base_in       = '0;
      op_end_in        = '0;
      op_idx_in        = '0;
      op_total_in      = '0;
      op_addend_in     = '0;
      op_div_in        = 1'b0;

      if (req_operation) begin
         phase_in         = tascs_pkg::PH_INIT;
         inner_step_in    = '0;
         outer_step_in    = '0;
         settle_origin_in = '0;
         dec_r0_en        = 1'b1;
         dec_cmd          = tascs_pkg::CMD_STOP_ALL;
      end else begin
         unique case (phase_ff)
            tascs_pkg::PH_INIT: begin
               in_start_in   = axis1_max_ff;
               in_end_in     = axis1_min_ff;
               out_start_in  = axis2_max_ff;
               out_end_in    = axis2_min_ff;
               inner_step_in = '0;
               outer_step_in = '0;
               // grid index 0 is the start itself
               dec_r0_en     = 1'b1;
               dec_cmd       = tascs_pkg::CMD_MOVE_OUTER;
               op_base_in    = axis2_max_ff;
               phase_in      = tascs_pkg::PH_OUTER_WAIT;
            end
            tascs_pkg::PH_OUTER_WAIT: begin
               if (!req_outer_moving) begin
                  dec_r0_en  = 1'b1;
                  dec_cmd    = tascs_pkg::CMD_MOVE_INNER;
                  op_base_in = in_start_ff;
                  if (inner_step_ff == 8'd0) begin
                     op_addend_in = {12'd0, home_seek_ff};
                     phase_in     = tascs_pkg::PH_HOME_SEEK;
                  end else begin
                     op_end_in   = in_end_ff;
                     op_idx_in   = inner_step_ff;
                     op_total_in = inner_div_ff;
                     op_div_in   = (inner_div_ff != 8'd0);
                     phase_in    = tascs_pkg::PH_INNER_WAIT;
                  end
               end
            end
            tascs_pkg::PH_HOME_SEEK: begin
               if (req_inner_limit_hit) begin
                  dec_r0_en        = 1'b1;
                  dec_cmd          = tascs_pkg::CMD_HOME_INNER;
                  op_base_in       = in_start_ff;
                  settle_origin_in = req_now_ms;
                  phase_in         = tascs_pkg::PH_SETTLE;
               end
            end
            tascs_pkg::PH_INNER_WAIT: begin
               if (!req_inner_moving) begin
                  settle_origin_in = req_now_ms;
                  phase_in         = tascs_pkg::PH_SETTLE;
               end
            end
            tascs_pkg::PH_SETTLE: begin
               if (settle_done) begin
                  phase_in = tascs_pkg::PH_CAP_START;
               end
            end
            tascs_pkg::PH_CAP_START: begin
               dec_r0_en = 1'b1;
               dec_cmd   = tascs_pkg::CMD_CAPTURE_START;
               phase_in  = tascs_pkg::PH_CAP_WAIT;
            end
            tascs_pkg::PH_CAP_WAIT: begin
               if (req_capture_complete) begin
                  phase_in = tascs_pkg::PH_FILTER;
               end
            end
            tascs_pkg::PH_FILTER: begin
               dec_r0_en        = 1'b1;
               dec_cmd          = tascs_pkg::CMD_FILTER;
               send_position_in = '0;
               phase_in         = tascs_pkg::PH_SEND;
            end
            tascs_pkg::PH_SEND: begin
               if (send_position_ff == 11'd0) begin
                  dec_r0_en = 1'b1;
                  dec_cmd   = tascs_pkg::CMD_HEADER;
                  dec_rin   = req_inner_position;
                  dec_rout  = req_outer_position;
                  dec_cnt   = cap_len;
               end
               if (send_position_ff < cap_len) begin
                  if (send_position_ff == 11'd0) begin
                     dec_r1_en = 1'b1;
                  end else begin
                     dec_r0_en = 1'b1;
                     dec_cmd   = tascs_pkg::CMD_SAMPLE;
                     dec_si    = req_sample_i;
                     dec_sq    = req_sample_q;
                  end
                  send_position_in = send_position_ff + 11'd1;
               end else begin
                  phase_in = tascs_pkg::PH_NEXT;
               end
            end
            tascs_pkg::PH_NEXT: begin
               dec_r0_en = 1'b1;
               if (inner_step_ff < inner_div_ff) begin
                  inner_step_in = inner_step_ff + 8'd1;
                  dec_cmd       = tascs_pkg::CMD_MOVE_INNER;
                  op_base_in    = in_start_ff;
                  op_end_in     = in_end_ff;
                  op_idx_in     = inner_step_ff + 8'd1;
                  op_total_in   = inner_div_ff;
                  op_div_in     = 1'b1;
                  phase_in      = tascs_pkg::PH_INNER_WAIT;
               end else if (outer_step_ff < outer_div_ff) begin
                  outer_step_in = outer_step_ff + 8'd1;
                  inner_step_in = '0;
                  dec_cmd       = tascs_pkg::CMD_MOVE_OUTER;
                  op_base_in    = out_start_ff;
                  op_end_in     = out_end_ff;
                  op_idx_in     = outer_step_ff + 8'd1;
                  op_total_in   = outer_div_ff;
                  op_div_in     = 1'b1;
                  phase_in      = tascs_pkg::PH_OUTER_WAIT;
               end else begin
                  dec_cmd  = tascs_pkg::CMD_END;
                  phase_in = tascs_pkg::PH_DONE;
               end
            end
            tascs_pkg::PH_DONE: ;
            default: phase_in = tascs_pkg::PH_DONE;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Shared unit: difference, magnitude product, restoring divide (one
   // quotient bit per cycle), then a single 32-bit add with sign fix.
   // ---------------------------------------------------------------------
   assign diff_in   = {op_end_ff[31], op_end_ff} - {op_base_ff[31], op_base_ff};
   assign mag       = diff_ff[32] ? (~diff_ff + 33'd1) : diff_ff;
   assign prod      = DW'(mag[31:0]) * DW'(op_idx_ff);
   assign trial     = {rem_ff, quo_ff[DW-1]};
   assign trial_ge  = (trial >= {1'b0, op_total_ff});
   assign trial_sub = trial - {1'b0, op_total_ff};
   // truncation toward zero: negate the magnitude quotient when negative
   assign add_operand = op_div_ff ? (quo_ff[31:0] ^ {32{neg_ff}}) : op_addend_ff;
   assign add_sum     = op_base_ff + add_operand + {31'd0, op_div_ff & neg_ff};

   // ---------------------------------------------------------------------
   // Control sequencer
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= tascs_pkg::ST_IDLE;
         phase_ff         <= tascs_pkg::PH_INIT;
         inner_step_ff    <= '0;
         outer_step_ff    <= '0;
         settle_origin_ff <= '0;
         send_position_ff <= '0;
         in_start_ff      <= '0;
         in_end_ff        <= '0;
         out_start_ff     <= '0;
         out_end_ff       <= '0;
         r1_pending_ff    <= 1'b0;
         cnt_ff           <= '0;
      end else begin
         unique case (state_ff)
            tascs_pkg::ST_IDLE: begin
               if (req_xfer) begin
                  phase_ff         <= phase_in;
                  inner_step_ff    <= inner_step_in;
                  outer_step_ff    <= outer_step_in;
                  settle_origin_ff <= settle_origin_in;
                  send_position_ff <= send_position_in;
                  in_start_ff      <= in_start_in;
                  in_end_ff        <= in_end_in;
                  out_start_ff     <= out_start_in;
                  out_end_ff       <= out_end_in;
                  r1_pending_ff    <= dec_r1_en;
                  if (dec_r0_en) begin
                     state_ff <= op_div_in ? tascs_pkg::ST_DIFF : tascs_pkg::ST_ADD;
                  end
               end
            end
            tascs_pkg::ST_DIFF: state_ff <= tascs_pkg::ST_MUL;
            tascs_pkg::ST_MUL: begin
               cnt_ff   <= '0;
               state_ff <= tascs_pkg::ST_DIV;
            end
            tascs_pkg::ST_DIV: begin
               cnt_ff <= cnt_ff + CW'(1);
               if (cnt_ff == CW'(DW - 1)) begin
                  state_ff <= tascs_pkg::ST_ADD;
               end
            end
            tascs_pkg::ST_ADD: state_ff <= tascs_pkg::ST_OUT;
            tascs_pkg::ST_OUT: begin
               if (rsp_xfer) begin
                  if (r1_pending_ff) begin
                     r1_pending_ff <= 1'b0;
                  end else begin
                     state_ff <= tascs_pkg::ST_IDLE;
                  end
               end
            end
            default: state_ff <= tascs_pkg::ST_IDLE;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Datapath registers (no reset)
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      unique case (state_ff)
         tascs_pkg::ST_IDLE: begin
            if (req_xfer) begin
               op_base_ff         <= op_base_in;
               op_end_ff          <= op_end_in;
               op_idx_ff          <= op_idx_in;
               op_total_ff        <= op_total_in;
               op_addend_ff       <= op_addend_in;
               op_div_ff          <= op_div_in;
               rsp_command_ff     <= dec_cmd;
               rsp_inner_index_ff <= inner_step_in;
               rsp_outer_index_ff <= outer_step_in;
               rsp_rin_ff         <= dec_rin;
               rsp_rout_ff        <= dec_rout;
               rsp_count_ff       <= dec_cnt;
               rsp_sample_i_ff    <= dec_si;
               rsp_sample_q_ff    <= dec_sq;
               rsp_last_ff        <= !dec_r1_en;
               r1_sample_i_ff     <= req_sample_i;
               r1_sample_q_ff     <= req_sample_q;
            end
         end
         tascs_pkg::ST_DIFF: diff_ff <= diff_in;
         tascs_pkg::ST_MUL: begin
            quo_ff <= prod;
            rem_ff <= '0;
            neg_ff <= diff_ff[32];
         end
         tascs_pkg::ST_DIV: begin
            quo_ff <= {quo_ff[DW-2:0], trial_ge};
            rem_ff <= trial_ge ? trial_sub[7:0] : trial[7:0];
         end
         tascs_pkg::ST_ADD: rsp_target_ff <= add_sum;
         tascs_pkg::ST_OUT: begin
            if (rsp_xfer && r1_pending_ff) begin
               rsp_command_ff  <= tascs_pkg::CMD_SAMPLE;
               rsp_target_ff   <= '0;
               rsp_rin_ff      <= '0;
               rsp_rout_ff     <= '0;
               rsp_count_ff    <= '0;
               rsp_sample_i_ff <= r1_sample_i_ff;
               rsp_sample_q_ff <= r1_sample_q_ff;
               rsp_last_ff     <= 1'b1;
            end
         end
         default: ;
      endcase
   end

`ifndef SYNTH
   // never ready while a result is waiting
   a_ready_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while a result is pending");

   // divider remainder always below the divisor
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tascs_pkg::ST_DIV) |-> (rem_ff < op_total_ff))
      else $error("divider remainder out of range");

   // a pending second result sits behind a header that is not last
   a_header_first: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && r1_pending_ff) |->
         (rsp_command_ff == tascs_pkg::CMD_HEADER) && !rsp_last_ff)
      else $error("second result without a leading header");

   // the final transfer of an item frees the request side
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && rsp_last) |=> req_ready)
      else $error("not ready after final result transfer");

   // sample position never passes the capture limit
   a_send_range: assert property (@(posedge clock) disable iff (reset)
      send_position_ff <= tascs_pkg::MAX_CAPTURE)
      else $error("send position beyond capture limit");
`endif

endmodule
